### design/legged_gait_sequencer_core_macros.svh
// Assertion helpers for the sequencer core.
`ifndef LEGGED_GAIT_SEQUENCER_CORE_MACROS_SVH
`define LEGGED_GAIT_SEQUENCER_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LGS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must be followed by another one on the next edge.
`define LGS_ASSERT_NEXT(lbl, cond, nxt, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

`endif

### design/lgs_pkg.sv
`timescale 1ns / 1ps
package lgs_pkg;

   localparam int POS_W  = 13;
   localparam int LEG_W  = 3;
   localparam int DIV_NW = 10;
   localparam int DIV_DW = 5;
   localparam int QUO_W  = 11;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_STEPS_IN_GAIT    = 3'd0;
   localparam logic [2:0] CSR_LIFTED_POSITIONS = 3'd1;
   localparam logic [2:0] CSR_FRONT_DOWN_POS   = 3'd2;
   localparam logic [2:0] CSR_LIFT_DIVISOR     = 3'd3;
   localparam logic [2:0] CSR_TRAVEL_DIVISOR   = 3'd4;
   localparam logic [2:0] CSR_HALF_LIFT_SHARE  = 3'd5;
   localparam logic [2:0] CSR_LIFT_HEIGHT      = 3'd6;
   localparam logic [2:0] CSR_LEG_OFFSETS      = 3'd7;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quo;
   } div_rsp_type;

   // Clamp a 14-bit signed value to the 13-bit signed range.
   function automatic logic signed [POS_W-1:0] sat13(input logic signed [POS_W:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 14'sd4095) begin
         r = 13'sd4095;
      end else if (v < -14'sd4096) begin
         r = -13'sd4096;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   // Halve an 8-bit signed value, truncating toward zero.
   function automatic logic signed [8:0] halve8(input logic signed [7:0] v);
      logic signed [8:0] e;
      e = {v[7], v} + {8'b0, v[7]};
      return e >>> 1;
   endfunction

endpackage

### design/lgs_divider.sv
`timescale 1ns / 1ps
module lgs_divider
   import lgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff;
   logic              done_ff;
   logic [3:0]        cnt_ff;
   logic [DIV_DW-1:0] rem_ff;
   logic [DIV_NW-1:0] quo_ff;
   logic [DIV_DW-1:0] den_ff;
   logic [DIV_DW:0]   shifted;
   logic              fits;

   // One restoring step per cycle: shift in a dividend bit, subtract if it fits.
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NW-1]};
      fits    = shifted >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 4'(DIV_NW);
            rem_ff  <= '0;
            quo_ff  <= div_req.num;
            den_ff  <= div_req.den;
         end else if (busy_ff) begin
            rem_ff <= fits ? DIV_DW'(shifted - {1'b0, den_ff}) : shifted[DIV_DW-1:0];
            quo_ff <= {quo_ff[DIV_NW-2:0], fits};
            cnt_ff <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

### design/legged_gait_sequencer_core.sv
`timescale 1ns / 1ps
// Gait sequencer core.
// A beat on the req_ channel is one gait tick: travel in x and z, turn and the
// walking flag. For it the block returns LEG_COUNT beats on the rsp_ channel,
// one per leg in order, each with the leg's updated gait offsets; last_leg
// marks the final one. Configuration registers are to be written by the user
// through csr_ only while no tick is in flight; the block does not enforce it.
// Per tick the block first runs seven divisions, one after another, on one
// shared bit-serial divider; then, for each leg in turn, it reads the leg's
// entry in the leg state memory, computes the update with write-back, and
// sends the result beat. The next tick is taken once the last leg beat has
// left.
// A stalled receiver holds the block at the pending leg beat; nothing is lost.
// Reset sets the registers to their defaults, the step counter to one and
// marks every leg entry as unwritten, so it reads as zero offsets; there is
// no clearing pass.
module legged_gait_sequencer_core
   import lgs_pkg::*;
#(
   parameter int LEG_COUNT = 6,
   parameter int DEAD_ZONE = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [7:0]       req_travel_x,
   input  logic signed [7:0]       req_travel_z,
   input  logic signed [7:0]       req_turn_y,
   input  logic                    req_walking,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [LEG_W-1:0]        rsp_leg_index,
   output logic signed [POS_W-1:0] rsp_offset_x,
   output logic signed [POS_W-1:0] rsp_offset_y,
   output logic signed [POS_W-1:0] rsp_offset_z,
   output logic signed [POS_W-1:0] rsp_rotation_y,
   output logic                    rsp_last_leg,
   input  logic                    csr_write_enable,
   input  logic [2:0]              csr_index,
   input  logic [29:0]             csr_write_data
);

`include "legged_gait_sequencer_core_macros.svh"

   localparam int LEG_AW = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
   localparam int WORD_W = 4 * POS_W;
   localparam logic [LEG_W-1:0] LAST_LEG = LEG_W'(LEG_COUNT - 1);

   // Division operations, in the order they run.
   localparam logic [2:0] OP_LIFT_X = 3'd0;
   localparam logic [2:0] OP_LIFT_Z = 3'd1;
   localparam logic [2:0] OP_LIFT_R = 3'd2;
   localparam logic [2:0] OP_MOVE_X = 3'd3;
   localparam logic [2:0] OP_MOVE_Z = 3'd4;
   localparam logic [2:0] OP_MOVE_R = 3'd5;
   localparam logic [2:0] OP_HALF   = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV_ISSUE, ST_DIV_WAIT, ST_RD, ST_CALC, ST_SEND
   } state_type;

   // Configuration registers.
   logic [4:0]  steps_ff, fdown_ff, tdiv_ff;
   logic [2:0]  nlift_ff, share_ff;
   logic [3:0]  ldiv_ff;
   logic [7:0]  lift_ff;
   logic [29:0] offs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= 5'd6;
         nlift_ff <= 3'd2;
         fdown_ff <= 5'd1;
         ldiv_ff  <= 4'd2;
         tdiv_ff  <= 5'd4;
         share_ff <= 3'd1;
         lift_ff  <= 8'd50;
         offs_ff  <= 30'd135398529;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STEPS_IN_GAIT:    steps_ff <= csr_write_data[4:0];
            CSR_LIFTED_POSITIONS: nlift_ff <= csr_write_data[2:0];
            CSR_FRONT_DOWN_POS:   fdown_ff <= csr_write_data[4:0];
            CSR_LIFT_DIVISOR:     ldiv_ff  <= csr_write_data[3:0];
            CSR_TRAVEL_DIVISOR:   tdiv_ff  <= csr_write_data[4:0];
            CSR_HALF_LIFT_SHARE:  share_ff <= csr_write_data[2:0];
            CSR_LIFT_HEIGHT:      lift_ff  <= csr_write_data[7:0];
            CSR_LEG_OFFSETS:      offs_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   state_type               state_ff;
   logic [LEG_W-1:0]        leg_ff;
   logic [2:0]              op_ff;
   logic [4:0]              step_ff;
   logic                    req_ff;
   logic signed [7:0]       tx_ff, tz_ff, ty_ff;
   logic signed [QUO_W-1:0] q_ff [7];
   logic                    rsp_valid_ff;
   logic [LEG_W-1:0]        rsp_leg_ff;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_r_ff;
   logic                    rsp_last_ff;

   // Travel request detection on the incoming beat.
   logic signed [8:0] ix9, iz9, iy9;
   logic              req_in;
   always_comb begin
      ix9 = {req_travel_x[7], req_travel_x};
      iz9 = {req_travel_z[7], req_travel_z};
      iy9 = {req_turn_y[7], req_turn_y};
      req_in = (ix9 > 9'(DEAD_ZONE)) || (-ix9 > 9'(DEAD_ZONE)) ||
               (iz9 > 9'(DEAD_ZONE)) || (-iz9 > 9'(DEAD_ZONE)) ||
               (iy9 > 9'(DEAD_ZONE)) || (-iy9 > 9'(DEAD_ZONE)) || req_walking;
   end

   // Operand selection for the shared divider.
   div_req_type       div_req;
   div_rsp_type       div_rsp;
   logic signed [7:0] src;
   logic signed [8:0] src9, mag9;
   logic              neg;
   logic [3:0]        ldiv_eff;
   logic [4:0]        tdiv_eff;
   logic signed [QUO_W-1:0] q_signed;

   always_comb begin
      ldiv_eff = (ldiv_ff == 4'd0) ? 4'd1 : ldiv_ff;
      tdiv_eff = (tdiv_ff == 5'd0) ? 5'd1 : tdiv_ff;
      case (op_ff) inside
         OP_LIFT_X, OP_MOVE_X: src = tx_ff;
         OP_LIFT_Z, OP_MOVE_Z: src = tz_ff;
         default:              src = ty_ff;
      endcase
      src9 = {src[7], src};
      mag9 = src9[8] ? -src9 : src9;
      div_req.start = (state_ff == ST_DIV_ISSUE);
      if (op_ff == OP_HALF) begin
         neg         = 1'b1;
         div_req.num = {1'b0, lift_ff, 1'b0} + {2'b0, lift_ff};
         div_req.den = 5'd3 + {2'b0, share_ff};
      end else begin
         neg         = src[7];
         div_req.num = {1'b0, mag9};
         div_req.den = (op_ff < OP_MOVE_X) ? {1'b0, ldiv_eff} : tdiv_eff;
      end
      q_signed = neg ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
   end

   lgs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Leg state memory: x, y, z and rotation packed in one word per leg.
   logic [WORD_W-1:0] mem [LEG_COUNT];
   logic [WORD_W-1:0] rd_data_ff;
   logic [LEG_COUNT-1:0] vld_ff;
   logic              rd_vld_ff;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [LEG_AW-1:0] addr;

   assign addr  = leg_ff[LEG_AW-1:0];
   assign wr_en = (state_ff == ST_CALC);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[addr];
         if (wr_en) begin
            vld_ff[addr] <= 1'b1;
         end
      end
   end

   // Per-leg update of the gait offsets.
   logic signed [POS_W-1:0] px, py, pz, pr;
   logic [4:0]              off;
   logic signed [6:0]       ls, st7, fd7;
   logic                    away, c_lift, c_back, c_fwd, c_back5, c_fwd5, c_down;
   logic signed [POS_W:0]   nx, ny, nz, nr;
   logic signed [POS_W:0]   lift14, half14;
   logic signed [POS_W-1:0] sx, sy, sz, sr;
   logic [5:0]              step_next;

   always_comb begin
      px = rd_vld_ff ? rd_data_ff[4*POS_W-1:3*POS_W] : '0;
      py = rd_vld_ff ? rd_data_ff[3*POS_W-1:2*POS_W] : '0;
      pz = rd_vld_ff ? rd_data_ff[2*POS_W-1:POS_W]   : '0;
      pr = rd_vld_ff ? rd_data_ff[POS_W-1:0]         : '0;
      off = '0;
      for (int i = 0; i < 6; i++) begin
         if (leg_ff == LEG_W'(i)) begin
            off = offs_ff[5*i +: 5];
         end
      end
      ls  = $signed({2'b0, step_ff}) - $signed({2'b0, off});
      st7 = $signed({2'b0, steps_ff});
      fd7 = $signed({2'b0, fdown_ff});
      away = (px > 13'sd2) || (px < -13'sd2) || (pz > 13'sd2) || (pz < -13'sd2) ||
             (pr > 13'sd2) || (pr < -13'sd2);
      c_lift  = (req_ff && nlift_ff[0] && ls == 7'sd0) ||
                (!req_ff && ls == 7'sd0 && away);
      c_back  = req_ff && ((nlift_ff == 3'd2 && ls == 7'sd0) ||
                (nlift_ff >= 3'd3 && (ls == -7'sd1 || ls == st7 - 7'sd1)));
      c_fwd   = req_ff && nlift_ff >= 3'd2 && (ls == 7'sd1 || ls == 7'sd1 - st7);
      c_back5 = req_ff && nlift_ff == 3'd5 && ls == -7'sd2;
      c_fwd5  = req_ff && nlift_ff == 3'd5 && (ls == 7'sd2 || ls == 7'sd2 - st7);
      c_down  = (ls == fd7 || ls == fd7 - st7) && py < 13'sd0;
      lift14  = $signed({6'b0, lift_ff});
      half14  = {{(POS_W+1-QUO_W){q_ff[6][QUO_W-1]}}, q_ff[6]};
      if (c_lift) begin
         nx = '0; ny = -lift14; nz = '0; nr = '0;
      end else if (c_back) begin
         nx = -{{3{q_ff[0][QUO_W-1]}}, q_ff[0]};
         ny = half14;
         nz = -{{3{q_ff[1][QUO_W-1]}}, q_ff[1]};
         nr = -{{3{q_ff[2][QUO_W-1]}}, q_ff[2]};
      end else if (c_fwd) begin
         nx = {{3{q_ff[0][QUO_W-1]}}, q_ff[0]};
         ny = half14;
         nz = {{3{q_ff[1][QUO_W-1]}}, q_ff[1]};
         nr = {{3{q_ff[2][QUO_W-1]}}, q_ff[2]};
      end else if (c_back5) begin
         nx = -14'(halve8(tx_ff));
         ny = -$signed({7'b0, lift_ff[7:1]});
         nz = -14'(halve8(tz_ff));
         nr = -14'(halve8(ty_ff));
      end else if (c_fwd5) begin
         nx = 14'(halve8(tx_ff));
         ny = -$signed({7'b0, lift_ff[7:1]});
         nz = 14'(halve8(tz_ff));
         nr = 14'(halve8(ty_ff));
      end else if (c_down) begin
         nx = 14'(halve8(tx_ff));
         ny = '0;
         nz = 14'(halve8(tz_ff));
         nr = 14'(halve8(ty_ff));
      end else begin
         nx = {px[POS_W-1], px} - {{3{q_ff[3][QUO_W-1]}}, q_ff[3]};
         ny = '0;
         nz = {pz[POS_W-1], pz} - {{3{q_ff[4][QUO_W-1]}}, q_ff[4]};
         nr = {pr[POS_W-1], pr} - {{3{q_ff[5][QUO_W-1]}}, q_ff[5]};
      end
      sx = sat13(nx);
      sy = sat13(ny);
      sz = sat13(nz);
      sr = sat13(nr);
      wr_data   = {sx, sy, sz, sr};
      step_next = {1'b0, step_ff} + 6'd1;
   end

   // Sequencer: divisions, then read, update and send for each leg.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         leg_ff       <= '0;
         op_ff        <= '0;
         step_ff      <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_in;
                  tx_ff    <= req_in ? req_travel_x : 8'sd0;
                  tz_ff    <= req_in ? req_travel_z : 8'sd0;
                  ty_ff    <= req_in ? req_turn_y : 8'sd0;
                  op_ff    <= OP_LIFT_X;
                  leg_ff   <= '0;
                  state_ff <= ST_DIV_ISSUE;
               end
            end
            ST_DIV_ISSUE: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_rsp.done) begin
                  q_ff[op_ff] <= q_signed;
                  if (op_ff == OP_HALF) begin
                     state_ff <= ST_RD;
                  end else begin
                     op_ff    <= op_ff + 3'd1;
                     state_ff <= ST_DIV_ISSUE;
                  end
               end
            end
            ST_RD: begin
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               rsp_valid_ff <= 1'b1;
               rsp_leg_ff   <= leg_ff;
               rsp_x_ff     <= sx;
               rsp_y_ff     <= sy;
               rsp_z_ff     <= sz;
               rsp_r_ff     <= sr;
               rsp_last_ff  <= (leg_ff == LAST_LEG);
               if (leg_ff == LAST_LEG) begin
                  step_ff <= (step_next > {1'b0, steps_ff}) ? 5'd1 : step_next[4:0];
               end
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (leg_ff == LAST_LEG) begin
                     leg_ff   <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     leg_ff   <= leg_ff + LEG_W'(1);
                     state_ff <= ST_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_leg_index  = rsp_leg_ff;
   assign rsp_offset_x   = rsp_x_ff;
   assign rsp_offset_y   = rsp_y_ff;
   assign rsp_offset_z   = rsp_z_ff;
   assign rsp_rotation_y = rsp_r_ff;
   assign rsp_last_leg   = rsp_last_ff;

   `LGS_ASSERT(a_beat_in_send, rsp_valid_ff == (state_ff == ST_SEND), "rsp beat outside send")
   `LGS_ASSERT(a_div_done_wait, !div_rsp.done || state_ff == ST_DIV_WAIT, "stray divide result")
   `LGS_ASSERT(a_step_nonzero, step_ff != 5'd0, "step counter reached zero")
   `LGS_ASSERT_NEXT(a_last_to_idle, state_ff == ST_SEND && rsp_ready && leg_ff == LAST_LEG,
      state_ff == ST_IDLE && leg_ff == '0, "tick did not close after last leg")

endmodule
